// File: sv/oslt_pkg.sv
package oslt_pkg;

    // fixed field widths
    localparam int ID_W      = 16;
    localparam int CFG_W     = 7;
    localparam int IDX_OUT_W = 6;

    // slots_in_use after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request, start first pass
        logic scan;       // issue reads for the current pass
        logic start2;     // start second pass (parent protection)
        logic fin_found;  // result: stored in the first empty slot
        logic evict;      // result: overwrite the chosen victim
        logic fin_none;   // result: nothing stored
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic found;
        logic need_pass2;
        logic any;
    } t_stat;

endpackage

// File: sv/oslt_ctrl.sv
module oslt_ctrl
    import oslt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN1 = 2'd1;
    localparam logic [1:0] S_SCAN2 = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN1;
                end
            end
            S_SCAN1: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    o_cmd.scan = 1'b0;
                    if (i_stat.found) begin
                        o_cmd.fin_found = 1'b1;
                        n_state         = S_OUT;
                    end else if (i_stat.need_pass2) begin
                        o_cmd.start2 = 1'b1;
                        n_state      = S_SCAN2;
                    end else begin
                        o_cmd.evict = 1'b1;
                        n_state     = S_OUT;
                    end
                end
            end
            S_SCAN2: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    o_cmd.scan = 1'b0;
                    if (i_stat.any) begin
                        o_cmd.evict = 1'b1;
                    end else begin
                        o_cmd.fin_none = 1'b1;
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/oslt_datapath.sv
module oslt_datapath
    import oslt_pkg::*;
#(
    parameter int SLOTS    = 64,
    parameter int AGE_BITS = 16
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [ID_W-1:0]      i_new_id,
    input  logic [ID_W-1:0]      i_parent_id,
    input  logic                 i_has_parent,
    output logic                 o_placed,
    output logic [IDX_OUT_W-1:0] o_slot_index,
    output logic                 o_evicted_valid,
    output logic [ID_W-1:0]      o_evicted_id
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = (CW > CFG_W) ? CW : CFG_W;
    localparam int DW = ID_W + AGE_BITS;

    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    // slot store: {id, age} per slot
    logic [DW-1:0] mem [SLOTS];

    logic [CFG_W-1:0]    r_slots_in_use;
    logic [CW-1:0]       r_fill;
    logic [CW-1:0]       r_n;
    logic                r_found;
    logic [ID_W-1:0]     r_nid;
    logic [ID_W-1:0]     r_pid;
    logic                r_hasp;
    logic [CW-1:0]       r_ptr;
    logic                r_pv;
    logic [IW-1:0]       r_pidx;
    logic                r_pass2;
    logic [AGE_BITS-1:0] r_best;
    logic [IW-1:0]       r_oldest;
    logic [ID_W-1:0]     r_oldest_id;
    logic                r_any;
    logic [DW-1:0]       r_q;
    logic                r_placed;
    logic [IW-1:0]       r_idx;
    logic                r_ev_valid;
    logic [ID_W-1:0]     r_ev_id;

    logic [XW-1:0]       cfg_x;
    logic [XW-1:0]       n_x;
    logic [CW-1:0]       n_load;
    logic                issue;
    logic [ID_W-1:0]     q_id;
    logic [AGE_BITS-1:0] q_age;
    logic [AGE_BITS-1:0] age_inc;
    logic [CW-1:0]       pidx_x;
    logic                in_fill;
    logic                at_fill;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [DW-1:0]       wr_data;
    logic [IW+IDX_OUT_W-1:0] idx_ext;

    // active slot count, clamped to 1..SLOTS
    always_comb begin
        cfg_x = XW'(r_slots_in_use);
        if (cfg_x == '0) begin
            n_x = XW'(1);
        end else if (cfg_x > XW'(SLOTS)) begin
            n_x = XW'(SLOTS);
        end else begin
            n_x = cfg_x;
        end
        n_load = n_x[CW-1:0];
    end

    // slot under inspection
    assign issue   = i_cmd.scan && (r_ptr != r_n);
    assign q_id    = r_q[DW-1:AGE_BITS];
    assign q_age   = r_q[AGE_BITS-1:0];
    assign age_inc = (q_age == AGE_MAX) ? q_age : q_age + AGE_BITS'(1);
    assign pidx_x  = CW'(r_pidx);
    assign in_fill = pidx_x < r_fill;
    assign at_fill = (pidx_x == r_fill) && r_found;

    // write port: age write-back, new id placement, victim overwrite
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pidx;
        wr_data = {q_id, age_inc};
        if (r_pv && !r_pass2) begin
            if (in_fill) begin
                wr_en = 1'b1;
            end else if (at_fill) begin
                wr_en   = 1'b1;
                wr_data = {r_nid, AGE_BITS'(0)};
            end
        end
        if (i_cmd.evict) begin
            wr_en   = 1'b1;
            wr_addr = r_oldest;
            wr_data = {r_nid, AGE_BITS'(0)};
        end
    end

    // slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_q <= mem[r_ptr[IW-1:0]];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= CFG_RESET;
            r_fill         <= '0;
            r_pv           <= 1'b0;
            r_ptr          <= '0;
            r_n            <= CW'(1);
        end else begin
            if (i_cfg_we) begin
                r_slots_in_use <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_n   <= n_load;
                r_ptr <= '0;
            end else if (i_cmd.start2) begin
                r_ptr <= '0;
            end else if (issue) begin
                r_ptr <= r_ptr + CW'(1);
            end
            r_pv <= issue;
            if (i_cmd.fin_found) begin
                r_fill <= r_fill + CW'(1);
            end
        end
    end

    // request capture, search and result registers
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pidx <= r_ptr[IW-1:0];
        end
        if (i_cmd.load) begin
            r_nid       <= i_new_id;
            r_pid       <= i_parent_id;
            r_hasp      <= i_has_parent;
            r_found     <= r_fill < n_load;
            r_pass2     <= 1'b0;
            r_best      <= '0;
            r_oldest    <= '0;
            r_oldest_id <= '0;
            r_any       <= 1'b0;
        end else if (i_cmd.start2) begin
            r_pass2 <= 1'b1;
            r_best  <= '0;
            r_any   <= 1'b0;
        end else if (r_pv) begin
            if (!r_pass2) begin
                // first pass: first slot of greatest aged value
                if (in_fill && (age_inc > r_best)) begin
                    r_best      <= age_inc;
                    r_oldest    <= r_pidx;
                    r_oldest_id <= q_id;
                end
            end else begin
                // second pass: last non-parent slot of greatest age
                if ((q_id != r_pid) && (q_age >= r_best)) begin
                    r_best      <= q_age;
                    r_oldest    <= r_pidx;
                    r_oldest_id <= q_id;
                    r_any       <= 1'b1;
                end
            end
        end
        if (i_cmd.fin_found) begin
            r_placed   <= 1'b1;
            r_idx      <= r_fill[IW-1:0];
            r_ev_valid <= 1'b0;
            r_ev_id    <= '0;
        end else if (i_cmd.evict) begin
            r_placed   <= 1'b1;
            r_idx      <= r_oldest;
            r_ev_valid <= 1'b1;
            r_ev_id    <= r_oldest_id;
        end else if (i_cmd.fin_none) begin
            r_placed   <= 1'b0;
            r_idx      <= '0;
            r_ev_valid <= 1'b0;
            r_ev_id    <= '0;
        end
    end

    // status to controller
    assign o_stat.scan_done  = (r_ptr == r_n) && !r_pv;
    assign o_stat.found      = r_found;
    assign o_stat.need_pass2 = r_hasp && (r_oldest_id == r_pid);
    assign o_stat.any        = r_any;

    // result beat
    assign idx_ext         = (IW + IDX_OUT_W)'(r_idx);
    assign o_placed        = r_placed;
    assign o_slot_index    = idx_ext[IDX_OUT_W-1:0];
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_id    = r_ev_id;

endmodule

// File: sv/oldest_slot_replacement_table_unit.sv
// channel   direction  signals
// in        input      i_in_valid / o_in_ready, i_new_id, i_parent_id, i_has_parent
// out       output     o_out_valid / i_out_ready, o_placed, o_slot_index,
//                      o_evicted_valid, o_evicted_id
// cfg       input      i_cfg_valid / o_cfg_ready (always ready), i_cfg_data
//
// one request at a time; with n active slots a request scans the n slots once
// when an empty slot exists or no parent check is needed, and twice with the
// parent pass, then waits for the result beat to be taken.
// the single read port of the slot memory reads one slot a cycle.
// synchronous active-low reset empties the table; no clearing pass is needed.
// the result is held until taken; no new request is taken while it waits.
module oldest_slot_replacement_table_unit
    import oslt_pkg::*;
#(
    parameter int SLOTS    = 64,
    parameter int AGE_BITS = 16
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [ID_W-1:0]      i_new_id,
    input  logic [ID_W-1:0]      i_parent_id,
    input  logic                 i_has_parent,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_placed,
    output logic [IDX_OUT_W-1:0] o_slot_index,
    output logic                 o_evicted_valid,
    output logic [ID_W-1:0]      o_evicted_id,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // register port never stalls
    assign o_cfg_ready = 1'b1;

    // sequencer
    oslt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // slot store and search
    oslt_datapath #(
        .SLOTS    (SLOTS),
        .AGE_BITS (AGE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_new_id        (i_new_id),
        .i_parent_id     (i_parent_id),
        .i_has_parent    (i_has_parent),
        .o_placed        (o_placed),
        .o_slot_index    (o_slot_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_id    (o_evicted_id)
    );

endmodule

// File: tb/sv/tb_oldest_slot_replacement_table_unit.sv
`timescale 1ns / 1ps

module tb_oldest_slot_replacement_table_unit;
    import oslt_pkg::*;

    localparam int NUM_SLOTS      = 64;
    localparam int AGE_W          = 16;
    localparam logic [AGE_W-1:0] AGE_TOP = {AGE_W{1'b1}};
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 2 * NUM_SLOTS + 20;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SHOWN_LIMIT    = 10;

    typedef struct packed {
        logic [ID_W-1:0] new_id;
        logic [ID_W-1:0] parent_id;
        logic            has_parent;
    } insert_req_t;

    typedef struct packed {
        logic                 placed;
        logic [IDX_OUT_W-1:0] slot_index;
        logic                 evicted_valid;
        logic [ID_W-1:0]      evicted_id;
    } insert_res_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [ID_W-1:0]      i_new_id = '0;
    logic [ID_W-1:0]      i_parent_id = '0;
    logic                 i_has_parent = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_placed;
    logic [IDX_OUT_W-1:0] o_slot_index;
    logic                 o_evicted_valid;
    logic [ID_W-1:0]      o_evicted_id;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // table as the testbench sees it
    logic             tbl_valid [NUM_SLOTS] = '{default: 1'b0};
    logic [ID_W-1:0]  tbl_id    [NUM_SLOTS] = '{default: '0};
    logic [AGE_W-1:0] tbl_age   [NUM_SLOTS] = '{default: '0};
    logic [CFG_W-1:0] slots_cfg = CFG_RESET;

    insert_res_t placements_due [$];
    int          mismatches = 0;
    int          send_gap_pct = 28;
    int          stall_pct = 76;
    int          hold_asked = 0;
    int          hold_taken = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    oldest_slot_replacement_table_unit #(
        .SLOTS    (NUM_SLOTS),
        .AGE_BITS (AGE_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_new_id        (i_new_id),
        .i_parent_id     (i_parent_id),
        .i_has_parent    (i_has_parent),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_placed        (o_placed),
        .o_slot_index    (o_slot_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_id    (o_evicted_id),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // zero counts as one slot, anything above the table size as the full table
    function automatic int active_count();
        if (slots_cfg == '0) return 1;
        if (slots_cfg > NUM_SLOTS) return NUM_SLOTS;
        return int'(slots_cfg);
    endfunction

    // ages the table, places or evicts, and returns the result beat
    function automatic insert_res_t apply_insert(input insert_req_t req);
        int               n;
        int               where;
        int               victim;
        bit               found;
        bit               any;
        logic [AGE_W-1:0] best;
        logic [AGE_W-1:0] top;
        insert_res_t      res;
        n = active_count();
        where = 0;
        victim = 0;
        found = 1'b0;
        best = '0;
        res = '0;
        // first pass: lowest empty slot, age the rest, track the oldest
        for (int i = 0; i < n; i++) begin
            if (!tbl_valid[i] && !found) begin
                tbl_valid[i] = 1'b1;
                tbl_id[i] = req.new_id;
                tbl_age[i] = '0;
                found = 1'b1;
                where = i;
            end else if (tbl_valid[i] && tbl_age[i] != AGE_TOP) begin
                tbl_age[i] = tbl_age[i] + AGE_W'(1);
            end
            if (tbl_age[i] > best) begin
                best = tbl_age[i];
                victim = i;
            end
        end
        if (found) begin
            res.placed = 1'b1;
            res.slot_index = IDX_OUT_W'(where);
            return res;
        end
        // victim holds the parent: last non-parent slot of greatest age
        if (req.has_parent && tbl_id[victim] == req.parent_id) begin
            any = 1'b0;
            top = '0;
            for (int i = 0; i < n; i++) begin
                if (tbl_id[i] != req.parent_id && tbl_age[i] >= top) begin
                    top = tbl_age[i];
                    victim = i;
                    any = 1'b1;
                end
            end
            if (!any) return res;
        end
        res.placed = 1'b1;
        res.slot_index = IDX_OUT_W'(victim);
        res.evicted_valid = 1'b1;
        res.evicted_id = tbl_id[victim];
        tbl_valid[victim] = 1'b1;
        tbl_id[victim] = req.new_id;
        tbl_age[victim] = '0;
        return res;
    endfunction

    // mostly a small pool so ids repeat, sometimes the full range
    function automatic logic [ID_W-1:0] any_id();
        if ($urandom_range(2) == 0) return ID_W'($urandom_range(65535));
        return ID_W'($urandom_range(7));
    endfunction

    // parent ids that hit the victim check often
    function automatic logic [ID_W-1:0] likely_parent();
        int n;
        int oldest;
        int pick;
        n = active_count();
        oldest = 0;
        for (int i = 1; i < n; i++) begin
            if (tbl_valid[i] && tbl_age[i] > tbl_age[oldest]) oldest = i;
        end
        pick = $urandom_range(n - 1);
        case ($urandom_range(4))
            0, 1: return tbl_valid[oldest] ? tbl_id[oldest] : any_id();
            2: return tbl_valid[pick] ? tbl_id[pick] : any_id();
            default: return any_id();
        endcase
    endfunction

    // one input beat, with an optional gap in front
    task automatic send_insert(input insert_req_t req);
        if ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        i_in_valid <= 1'b1;
        i_new_id <= req.new_id;
        i_parent_id <= req.parent_id;
        i_has_parent <= req.has_parent;
        do @(posedge i_clk); while (!o_in_ready);
        placements_due.push_back(apply_insert(req));
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_placements();
        i_in_valid <= 1'b0;
        while (placements_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // config write only once the block is idle
    task automatic set_slots_in_use(input logic [CFG_W-1:0] value);
        drain_placements();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        slots_cfg = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_inserts(input int count);
        insert_req_t req;
        for (int k = 0; k < count; k++) begin
            req.has_parent = ($urandom_range(3) != 0);
            req.parent_id = likely_parent();
            // sometimes store the parent itself so tables fill with it
            req.new_id = ($urandom_range(3) == 0) ? req.parent_id : any_id();
            send_insert(req);
        end
    endtask

    task automatic test_fill_and_evict();
        set_slots_in_use(7'd3);
        send_insert(insert_req_t'{16'hFFFF, 16'h0000, 1'b0});
        send_insert(insert_req_t'{16'h0000, 16'hFFFF, 1'b1});
        send_insert(insert_req_t'{16'hA5A5, 16'h5A5A, 1'b1});
        // full table, no parent: oldest goes
        send_insert(insert_req_t'{16'h1234, 16'hFFFF, 1'b0});
        // oldest holds the parent: protected
        send_insert(insert_req_t'{16'h5678, 16'h0000, 1'b1});
    endtask

    task automatic test_all_parent_held();
        // zero active slots behaves as one
        set_slots_in_use(7'd0);
        send_insert(insert_req_t'{16'h0777, 16'h0000, 1'b0});
        send_insert(insert_req_t'{16'h0888, 16'h0777, 1'b1});
        send_insert(insert_req_t'{16'h0999, 16'h0777, 1'b1});
        send_insert(insert_req_t'{16'h0777, 16'h0777, 1'b0});
        set_slots_in_use(7'd2);
        send_insert(insert_req_t'{16'h0777, 16'h0777, 1'b1});
        send_insert(insert_req_t'{16'h0777, 16'h0777, 1'b1});
    endtask

    task automatic test_active_count_limits();
        // above the table size behaves as the full table
        set_slots_in_use(7'd127);
        send_insert(insert_req_t'{16'hF0F0, 16'h0F0F, 1'b1});
        send_insert(insert_req_t'{16'h0F0F, 16'hF0F0, 1'b1});
        send_insert(insert_req_t'{16'hFFFF, 16'hFFFF, 1'b1});
        send_insert(insert_req_t'{16'h0000, 16'h0000, 1'b0});
        // slots beyond the active range keep their contents
        set_slots_in_use(7'd3);
        send_insert(insert_req_t'{16'h4321, 16'h0777, 1'b1});
        send_insert(insert_req_t'{16'h8765, 16'h4321, 1'b1});
    endtask

    task automatic test_random_slow_receiver();
        send_gap_pct = 28;
        stall_pct = 76;
        set_slots_in_use(7'd64);
        random_inserts(150);
        set_slots_in_use(7'd4);
        random_inserts(200);
    endtask

    task automatic test_random_slow_sender();
        send_gap_pct = 76;
        stall_pct = 28;
        set_slots_in_use(7'd1);
        random_inserts(100);
        set_slots_in_use(7'd127);
        random_inserts(100);
        set_slots_in_use(7'd9);
        random_inserts(120);
    endtask

    task automatic test_random_full_rate();
        send_gap_pct = 0;
        stall_pct = 0;
        set_slots_in_use(7'd2);
        random_inserts(150);
        set_slots_in_use(CFG_W'($urandom_range(127)));
        random_inserts(150);
        set_slots_in_use(7'd64);
        random_inserts(100);
    endtask

    // receiver stops for a long stretch while requests keep coming
    task automatic test_output_backpressure();
        send_gap_pct = 0;
        stall_pct = 0;
        set_slots_in_use(7'd6);
        hold_asked++;
        random_inserts(40);
    endtask

    // receiver: random stalls, plus a long hold on request
    always @(posedge i_clk) begin
        if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= SHOWN_LIMIT)
                $display("mismatch on %s: expected %0h, got %0h", field, want, got);
        end
    endtask

    // compare each result beat with the oldest outstanding insert
    always @(posedge i_clk) begin
        insert_res_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (placements_due.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_LIMIT)
                    $display("result beat with no insert outstanding");
            end else begin
                want = placements_due.pop_front();
                check_field("placed", 32'(want.placed), 32'(o_placed));
                check_field("slot_index", 32'(want.slot_index), 32'(o_slot_index));
                check_field("evicted_valid", 32'(want.evicted_valid),
                            32'(o_evicted_valid));
                check_field("evicted_id", 32'(want.evicted_id), 32'(o_evicted_id));
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_and_evict();
        test_all_parent_held();
        test_active_count_limits();
        test_random_slow_receiver();
        test_random_slow_sender();
        test_random_full_rate();
        test_output_backpressure();
        drain_placements();
        repeat (END_CYCLES) @(posedge i_clk);
        if (placements_due.size() != 0) begin
            mismatches++;
            $display("%0d results never arrived", placements_due.size());
        end
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
